>>> rtl/core/priority_upload_queue_with_byte_caps_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority upload queue
// Shared property wrappers, clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_UPLOAD_QUEUE_WITH_BYTE_CAPS_UNIT_MACROS_SVH
`define PRIORITY_UPLOAD_QUEUE_WITH_BYTE_CAPS_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PUPQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PUPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pupq_pkg.sv
// ----------------------------------------------------------------------------
// pupq_pkg
// Widths, codes and shared types of the priority upload queue.
// ----------------------------------------------------------------------------
package pupq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 256;
   localparam int CLASSES     = 4;
   localparam int CLS_W       = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = CLS_W + PTR_W;
   localparam int ENTRY_DEPTH = CLASSES * QUEUE_DEPTH;

   // field widths
   localparam int TAG_W     = 16;
   localparam int BYTES_W   = 24;
   localparam int ENTRY_W   = TAG_W + BYTES_W;
   localparam int KIND_W    = 2;
   localparam int ITEMS_W   = 11;
   localparam int QBYTES_W  = 32;
   localparam int CAP_W     = 31;
   localparam int INFL_W    = 8;
   localparam int DROP_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 31;

   // register reset values
   localparam logic [CAP_W-1:0]  SOFT_CAP_RESET      = CAP_W'(128 * 1024 * 1024);
   localparam logic [CAP_W-1:0]  HARD_CAP_RESET      = CAP_W'(256 * 1024 * 1024);
   localparam logic [INFL_W-1:0] MAX_IN_FLIGHT_RESET = INFL_W'(3);

   // command codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ENQUEUE        = 2'd0,
      KIND_GATED_DRAIN    = 2'd1,
      KIND_SHUTDOWN_DRAIN = 2'd2,
      KIND_COMPLETION     = 2'd3
   } kind_type;

   // traffic classes, highest priority first
   typedef enum logic [CLS_W-1:0] {
      CLS_METADATA = 2'd0,
      CLS_LOGS     = 2'd1,
      CLS_METRICS  = 2'd2,
      CLS_TRACES   = 2'd3
   } class_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOFT_CAP      = 2'd0,
      CSR_HARD_CAP      = 2'd1,
      CSR_MAX_IN_FLIGHT = 2'd2
   } csr_index_type;

   // controller states
   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // configuration seen by the controller
   typedef struct packed {
      logic [CAP_W-1:0]  soft_cap;
      logic [CAP_W-1:0]  hard_cap;
      logic [INFL_W-1:0] max_in_flight;
   } cfg_type;

   // entry memory access
   typedef struct packed {
      logic              write_en;
      logic              read_en;
      logic [ADDR_W-1:0] addr;
      logic [ENTRY_W-1:0] write_data;
   } mem_req_type;

endpackage

>>> rtl/core/priority_upload_queue_with_byte_caps_unit.sv
// ----------------------------------------------------------------------------
// priority_upload_queue_with_byte_caps_unit
// Four-class strict-priority upload queue with byte-cap admission.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+------------------------------
//   command | start, busy, req_*             | taken when start && !busy
//   result  | rsp_strobe, rsp_*              | one-cycle strobe, no stall
//   config  | csr_write_enable, csr_index,   | written when csr_write_enable
//           | csr_write_data                 |
//
// Each command reads the class entry from the single-port entry memory in the
// idle state at accept, then writes back and updates counters in the execute state.
// The result word strobes in the cycle after execute, and busy is already low
// then, so a new command can be taken while the result word strobes.
// Reset is synchronous; pointers and totals clear, the entry memory does not.
// Results are never held back by the receiver.
// ----------------------------------------------------------------------------
module priority_upload_queue_with_byte_caps_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pupq_pkg::KIND_W-1:0]   req_kind,
   input  logic [pupq_pkg::CLS_W-1:0]    req_priority_req,
   input  logic [pupq_pkg::BYTES_W-1:0]  req_payload_bytes,
   input  logic [pupq_pkg::TAG_W-1:0]    req_tag,
   output logic                          rsp_strobe,
   output logic                          rsp_accepted,
   output logic                          rsp_dropped,
   output logic                          rsp_issued,
   output logic [pupq_pkg::TAG_W-1:0]    rsp_issued_tag,
   output logic [pupq_pkg::CLS_W-1:0]    rsp_issued_priority,
   output logic [pupq_pkg::BYTES_W-1:0]  rsp_issued_bytes,
   output logic [pupq_pkg::QBYTES_W-1:0] rsp_queued_bytes_now,
   output logic [pupq_pkg::ITEMS_W-1:0]  rsp_queued_items_now,
   output logic [pupq_pkg::INFL_W-1:0]   rsp_in_flight_now,
   output logic [pupq_pkg::DROP_W-1:0]   rsp_drop_total_now,
   input  logic                          csr_write_enable,
   input  logic [pupq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pupq_pkg::CSR_W-1:0]    csr_write_data
);
   import pupq_pkg::*;

   logic [CAP_W-1:0]  soft_cap_ff;
   logic [CAP_W-1:0]  hard_cap_ff;
   logic [INFL_W-1:0] max_in_flight_ff;
   cfg_type           cfg;
   mem_req_type       mem_req;
   logic [ENTRY_W-1:0] mem_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         soft_cap_ff      <= SOFT_CAP_RESET;
         hard_cap_ff      <= HARD_CAP_RESET;
         max_in_flight_ff <= MAX_IN_FLIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOFT_CAP:      soft_cap_ff      <= csr_write_data[CAP_W-1:0];
            CSR_HARD_CAP:      hard_cap_ff      <= csr_write_data[CAP_W-1:0];
            CSR_MAX_IN_FLIGHT: max_in_flight_ff <= csr_write_data[INFL_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.soft_cap      = soft_cap_ff;
   assign cfg.hard_cap      = hard_cap_ff;
   assign cfg.max_in_flight = max_in_flight_ff;

   // sequencer
   pupq_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_priority_req     (req_priority_req),
      .req_payload_bytes    (req_payload_bytes),
      .req_tag              (req_tag),
      .cfg                  (cfg),
      .mem_req              (mem_req),
      .mem_rd_data          (mem_rd_data),
      .rsp_strobe           (rsp_strobe),
      .rsp_accepted         (rsp_accepted),
      .rsp_dropped          (rsp_dropped),
      .rsp_issued           (rsp_issued),
      .rsp_issued_tag       (rsp_issued_tag),
      .rsp_issued_priority  (rsp_issued_priority),
      .rsp_issued_bytes     (rsp_issued_bytes),
      .rsp_queued_bytes_now (rsp_queued_bytes_now),
      .rsp_queued_items_now (rsp_queued_items_now),
      .rsp_in_flight_now    (rsp_in_flight_now),
      .rsp_drop_total_now   (rsp_drop_total_now)
   );

   // entry store for all class FIFOs
   pupq_entry_ram u_entry_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

endmodule

>>> rtl/core/pupq_entry_ram.sv
// ----------------------------------------------------------------------------
// pupq_entry_ram
// Single-port entry store for all class FIFOs, registered read data.
// ----------------------------------------------------------------------------
module pupq_entry_ram (
   input  logic                          clock,
   input  pupq_pkg::mem_req_type         mem_req,
   output logic [pupq_pkg::ENTRY_W-1:0]  rd_data
);
   import pupq_pkg::*;

   logic [ENTRY_W-1:0] mem_ff [ENTRY_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // write port, contents undefined until written
   always_ff @(posedge clock) begin
      if (mem_req.write_en) begin
         mem_ff[mem_req.addr] <= mem_req.write_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (mem_req.read_en) begin
         rd_data_ff <= mem_ff[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pupq_ctrl.sv
// ----------------------------------------------------------------------------
// pupq_ctrl
// Command sequencer: class pointers, admission, drain select and counters.
// ----------------------------------------------------------------------------
`include "priority_upload_queue_with_byte_caps_unit_macros.svh"

module pupq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pupq_pkg::KIND_W-1:0]   req_kind,
   input  logic [pupq_pkg::CLS_W-1:0]    req_priority_req,
   input  logic [pupq_pkg::BYTES_W-1:0]  req_payload_bytes,
   input  logic [pupq_pkg::TAG_W-1:0]    req_tag,
   input  pupq_pkg::cfg_type             cfg,
   output pupq_pkg::mem_req_type         mem_req,
   input  logic [pupq_pkg::ENTRY_W-1:0]  mem_rd_data,
   output logic                          rsp_strobe,
   output logic                          rsp_accepted,
   output logic                          rsp_dropped,
   output logic                          rsp_issued,
   output logic [pupq_pkg::TAG_W-1:0]    rsp_issued_tag,
   output logic [pupq_pkg::CLS_W-1:0]    rsp_issued_priority,
   output logic [pupq_pkg::BYTES_W-1:0]  rsp_issued_bytes,
   output logic [pupq_pkg::QBYTES_W-1:0] rsp_queued_bytes_now,
   output logic [pupq_pkg::ITEMS_W-1:0]  rsp_queued_items_now,
   output logic [pupq_pkg::INFL_W-1:0]   rsp_in_flight_now,
   output logic [pupq_pkg::DROP_W-1:0]   rsp_drop_total_now
);
   import pupq_pkg::*;

   fsm_type state_ff, state_in;
   logic    accept;

   // per-class FIFO pointers and fill levels
   logic [PTR_W-1:0]  heads_ff [CLASSES];
   logic [PTR_W-1:0]  tails_ff [CLASSES];
   logic [FILL_W-1:0] fill_ff  [CLASSES];

   // totals
   logic [QBYTES_W-1:0] queued_bytes_ff, queued_bytes_in;
   logic [ITEMS_W-1:0]  queued_items_ff, queued_items_in;
   logic [INFL_W-1:0]   outstanding_ff, outstanding_in;
   logic [DROP_W-1:0]   drop_count_ff, drop_count_in;

   // latched command
   kind_type           op_kind_ff;
   class_type          op_cls_ff;
   logic [PTR_W-1:0]   op_ptr_ff;
   logic               op_found_ff;
   logic [BYTES_W-1:0] op_bytes_ff;
   logic [TAG_W-1:0]   op_tag_ff;

   // response payload
   logic               rsp_strobe_ff;
   logic               rsp_accepted_ff, rsp_dropped_ff, rsp_issued_ff;
   logic [TAG_W-1:0]   rsp_issued_tag_ff;
   logic [CLS_W-1:0]   rsp_issued_priority_ff;
   logic [BYTES_W-1:0] rsp_issued_bytes_ff;

   // accept-side selection
   logic               any_filled;
   logic [CLS_W-1:0]   drain_cls;
   logic [CLS_W-1:0]   sel_cls;
   logic [PTR_W-1:0]   sel_ptr;
   kind_type           req_kind_c;

   // execute-side decisions
   logic [CAP_W-1:0]    hard_eff;
   logic                cap_drop, fifo_full, admit, refuse, gate_ok, issue;
   logic [PTR_W-1:0]    ptr_next;
   logic [FILL_W-1:0]   fill_sel;
   logic [QBYTES_W:0]   bytes_sum;
   logic [TAG_W-1:0]    rd_tag;
   logic [BYTES_W-1:0]  rd_bytes;
   logic [QBYTES_W-1:0] rd_bytes_ext;

   assign req_kind_c = kind_type'(req_kind);
   assign accept     = start && (state_ff == FSM_IDLE);

   // highest-priority non-empty class
   always_comb begin
      any_filled = 1'b0;
      drain_cls  = '0;
      for (int c = CLASSES - 1; c >= 0; c--) begin
         if (fill_ff[c] != '0) begin
            any_filled = 1'b1;
            drain_cls  = CLS_W'(c);
         end
      end
   end

   // entry pointer for the command being taken
   assign sel_cls = (req_kind_c == KIND_ENQUEUE) ? req_priority_req : drain_cls;
   assign sel_ptr = (req_kind_c == KIND_ENQUEUE) ? tails_ff[sel_cls] : heads_ff[sel_cls];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (start) state_in = FSM_EXEC;
         end
         FSM_EXEC: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // state outputs: busy flag and memory port
   always_comb begin
      busy    = 1'b0;
      mem_req = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            mem_req.read_en = accept;
            mem_req.addr    = {sel_cls, sel_ptr};
         end
         FSM_EXEC: begin
            busy               = 1'b1;
            mem_req.write_en   = admit;
            mem_req.addr       = {op_cls_ff, op_ptr_ff};
            mem_req.write_data = {op_tag_ff, op_bytes_ff};
         end
         default: busy = 1'b1;
      endcase
   end

   // admission and drain decisions
   assign hard_eff  = (cfg.hard_cap > cfg.soft_cap) ? cfg.hard_cap : cfg.soft_cap;
   assign fill_sel  = fill_ff[op_cls_ff];
   assign cap_drop  = ((op_cls_ff == CLS_TRACES) &&
                       (queued_bytes_ff >= {1'b0, cfg.soft_cap})) ||
                      ((op_cls_ff != CLS_METADATA) &&
                       (queued_bytes_ff >= {1'b0, hard_eff}));
   assign fifo_full = (fill_sel >= FILL_W'(QUEUE_DEPTH));
   assign ptr_next  = (op_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : op_ptr_ff + 1'b1;

   always_comb begin
      admit   = 1'b0;
      refuse  = 1'b0;
      gate_ok = 1'b0;
      case (op_kind_ff)
         KIND_ENQUEUE: begin
            admit  = !cap_drop && !fifo_full;
            refuse = cap_drop || fifo_full;
         end
         KIND_GATED_DRAIN:    gate_ok = (outstanding_ff < cfg.max_in_flight);
         KIND_SHUTDOWN_DRAIN: gate_ok = 1'b1;
         default:             gate_ok = 1'b0;
      endcase
      admit  = admit && (state_ff == FSM_EXEC);
      refuse = refuse && (state_ff == FSM_EXEC);
   end

   assign issue = (state_ff == FSM_EXEC) && gate_ok && op_found_ff;

   assign rd_tag       = mem_rd_data[ENTRY_W-1:BYTES_W];
   assign rd_bytes     = mem_rd_data[BYTES_W-1:0];
   assign rd_bytes_ext = {{(QBYTES_W - BYTES_W){1'b0}}, rd_bytes};
   assign bytes_sum    = {1'b0, queued_bytes_ff} +
                         {{(QBYTES_W + 1 - BYTES_W){1'b0}}, op_bytes_ff};

   // totals after the step
   always_comb begin
      queued_bytes_in = queued_bytes_ff;
      queued_items_in = queued_items_ff;
      outstanding_in  = outstanding_ff;
      drop_count_in   = drop_count_ff;
      if (admit) begin
         queued_items_in = queued_items_ff + 1'b1;
         queued_bytes_in = bytes_sum[QBYTES_W] ? '1 : bytes_sum[QBYTES_W-1:0];
      end
      if (refuse && (drop_count_ff != '1)) begin
         drop_count_in = drop_count_ff + 1'b1;
      end
      if (issue) begin
         if (queued_items_ff != '0) queued_items_in = queued_items_ff - 1'b1;
         queued_bytes_in = (queued_bytes_ff > rd_bytes_ext) ?
                           queued_bytes_ff - rd_bytes_ext : '0;
         if (outstanding_ff != '1) outstanding_in = outstanding_ff + 1'b1;
      end
      if ((state_ff == FSM_EXEC) && (op_kind_ff == KIND_COMPLETION) &&
          (outstanding_ff != '0)) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FSM_IDLE;
         queued_bytes_ff <= '0;
         queued_items_ff <= '0;
         outstanding_ff  <= '0;
         drop_count_ff   <= '0;
         rsp_strobe_ff   <= 1'b0;
         for (int c = 0; c < CLASSES; c++) begin
            heads_ff[c] <= '0;
            tails_ff[c] <= '0;
            fill_ff[c]  <= '0;
         end
      end else begin
         state_ff        <= state_in;
         queued_bytes_ff <= queued_bytes_in;
         queued_items_ff <= queued_items_in;
         outstanding_ff  <= outstanding_in;
         drop_count_ff   <= drop_count_in;
         rsp_strobe_ff   <= (state_ff == FSM_EXEC);
         if (admit) begin
            tails_ff[op_cls_ff] <= ptr_next;
            fill_ff[op_cls_ff]  <= fill_sel + 1'b1;
         end
         if (issue) begin
            heads_ff[op_cls_ff] <= ptr_next;
            fill_ff[op_cls_ff]  <= fill_sel - 1'b1;
         end
      end
   end

   // command latch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_kind_ff  <= req_kind_c;
         op_cls_ff   <= class_type'(sel_cls);
         op_ptr_ff   <= sel_ptr;
         op_found_ff <= any_filled;
         op_bytes_ff <= req_payload_bytes;
         op_tag_ff   <= req_tag;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (state_ff == FSM_EXEC) begin
         rsp_accepted_ff        <= admit;
         rsp_dropped_ff         <= refuse;
         rsp_issued_ff          <= issue;
         rsp_issued_tag_ff      <= issue ? rd_tag : '0;
         rsp_issued_priority_ff <= issue ? op_cls_ff : '0;
         rsp_issued_bytes_ff    <= issue ? rd_bytes : '0;
      end
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_accepted         = rsp_accepted_ff;
   assign rsp_dropped          = rsp_dropped_ff;
   assign rsp_issued           = rsp_issued_ff;
   assign rsp_issued_tag       = rsp_issued_tag_ff;
   assign rsp_issued_priority  = rsp_issued_priority_ff;
   assign rsp_issued_bytes     = rsp_issued_bytes_ff;
   // totals stay put until the next command executes
   assign rsp_queued_bytes_now = queued_bytes_ff;
   assign rsp_queued_items_now = queued_items_ff;
   assign rsp_in_flight_now    = outstanding_ff;
   assign rsp_drop_total_now   = drop_count_ff;

   // checks
   `PUPQ_ASSERT_NEXT(a_exec_after_accept, start && !busy, state_ff == FSM_EXEC,
      "accepted command did not enter execute")
   `PUPQ_ASSERT_NEXT(a_strobe_after_exec, state_ff == FSM_EXEC, rsp_strobe_ff,
      "execute cycle produced no response word")
   `PUPQ_ASSERT_SAME(a_single_outcome, rsp_strobe_ff,
      !(rsp_accepted_ff && rsp_dropped_ff) &&
      !((rsp_accepted_ff || rsp_dropped_ff) && rsp_issued_ff),
      "response word carries conflicting outcomes")
   `PUPQ_ASSERT_SAME(a_items_match_fill, 1'b1,
      queued_items_ff == ITEMS_W'(fill_ff[0]) + ITEMS_W'(fill_ff[1]) +
                         ITEMS_W'(fill_ff[2]) + ITEMS_W'(fill_ff[3]),
      "queued item count disagrees with class fill levels")

endmodule
